// ----- rtl/core/assert_macros.svh -----
// assertion helpers, sampled on clk and held off while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// condition must never hold
`define ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed: forbidden condition");

`endif

// ----- rtl/core/rcd_pkg.sv -----
package rcd_pkg;

  localparam int unsigned INSN_W = 32;

  // major opcodes
  localparam logic [6:0] OPC_RTYPE  = 7'b0110011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_IMM    = 7'b0010011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_STOP   = 7'b1111111;

  // funct7 values
  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;

  // funct3 values used by the decoder
  localparam logic [2:0] F3_ADD  = 3'b000;
  localparam logic [2:0] F3_SLL  = 3'b001;
  localparam logic [2:0] F3_SLT  = 3'b010;
  localparam logic [2:0] F3_SLTU = 3'b011;
  localparam logic [2:0] F3_XOR  = 3'b100;
  localparam logic [2:0] F3_SRL  = 3'b101;
  localparam logic [2:0] F3_OR   = 3'b110;
  localparam logic [2:0] F3_AND  = 3'b111;

  typedef enum logic [2:0] {
    OPND_RS2   = 3'd0,
    OPND_IMM_I = 3'd1,
    OPND_IMM_S = 3'd2,
    OPND_IMM_B = 3'd3,
    OPND_RD    = 3'd4,
    OPND_IMM_U = 3'd5,
    OPND_IMM_J = 3'd6
  } operand_sel_t;

  typedef enum logic [3:0] {
    ALU_ADD   = 4'd0,
    ALU_SUB   = 4'd1,
    ALU_MUL   = 4'd2,
    ALU_DIV   = 4'd3,
    ALU_PASSB = 4'd4,
    ALU_AND   = 4'd5,
    ALU_XOR   = 4'd6,
    ALU_OR    = 4'd7,
    ALU_LT    = 4'd8,
    ALU_SHL   = 4'd9,
    ALU_SHR   = 4'd10,
    ALU_INC   = 4'd11
  } alu_code_t;

  typedef struct packed {
    logic         reg_write;
    logic         mem_write;
    operand_sel_t operand_select;
    alu_code_t    alu_code;
    logic         result_from_alu;
    logic         conditional;
    logic         halt;
    logic         pc_operand;
    logic         jump;
  } ctrl_word_t;

endpackage

// ----- rtl/core/rcd_insn_if.sv -----
interface rcd_insn_if;
  logic                        valid;
  logic                        ready;
  logic [rcd_pkg::INSN_W-1:0]  instruction;

  modport source (output valid, output instruction, input ready);
  modport sink   (input valid, input instruction, output ready);
endinterface

// ----- rtl/core/rcd_ctrl_if.sv -----
interface rcd_ctrl_if;
  logic       valid;
  logic       ready;
  logic       reg_write;
  logic       mem_write;
  logic [2:0] operand_select;
  logic [3:0] alu_code;
  logic       result_from_alu;
  logic       conditional;
  logic       halt;
  logic       pc_operand;
  logic       jump;

  modport source (
    output valid, output reg_write, output mem_write, output operand_select,
    output alu_code, output result_from_alu, output conditional, output halt,
    output pc_operand, output jump, input ready
  );
  modport sink (
    input valid, input reg_write, input mem_write, input operand_select,
    input alu_code, input result_from_alu, input conditional, input halt,
    input pc_operand, input jump, output ready
  );
endinterface

// ----- rtl/core/rcd_decode.sv -----
module rcd_decode (
  input  logic [rcd_pkg::INSN_W-1:0] insn,
  output rcd_pkg::ctrl_word_t        word
);

  logic [6:0] opc;
  logic [2:0] f3;
  logic [6:0] f7;

  assign opc = insn[6:0];
  assign f3  = insn[14:12];
  assign f7  = insn[31:25];

  // main decode, unknown encodings leave the word cleared
  always_comb begin
    word = '0;
    unique case (opc)
      rcd_pkg::OPC_RTYPE: begin
        word.reg_write       = 1'b1;
        word.result_from_alu = 1'b1;
        word.operand_select  = rcd_pkg::OPND_RS2;
        unique case (f3)
          rcd_pkg::F3_ADD: begin
            if (f7 == rcd_pkg::F7_BASE) begin
              word.alu_code = rcd_pkg::ALU_ADD;
            end else if (f7 == rcd_pkg::F7_ALT) begin
              word.alu_code = rcd_pkg::ALU_SUB;
            end else begin
              word = '0;
            end
          end
          rcd_pkg::F3_SRL: begin
            // sra shares the srl code
            if (f7 == rcd_pkg::F7_BASE || f7 == rcd_pkg::F7_ALT) begin
              word.alu_code = rcd_pkg::ALU_SHR;
            end else begin
              word = '0;
            end
          end
          rcd_pkg::F3_SLL: word.alu_code = rcd_pkg::ALU_SHL;
          rcd_pkg::F3_SLT, rcd_pkg::F3_SLTU: word.alu_code = rcd_pkg::ALU_LT;
          rcd_pkg::F3_XOR: word.alu_code = rcd_pkg::ALU_XOR;
          rcd_pkg::F3_OR:  word.alu_code = rcd_pkg::ALU_OR;
          rcd_pkg::F3_AND: word.alu_code = rcd_pkg::ALU_AND;
          default: word = '0;
        endcase
      end
      rcd_pkg::OPC_LOAD: begin
        unique case (f3) inside
          rcd_pkg::F3_ADD, rcd_pkg::F3_SLL, rcd_pkg::F3_SLT,
          rcd_pkg::F3_XOR, rcd_pkg::F3_SRL: begin
            word.reg_write      = 1'b1;
            word.operand_select = rcd_pkg::OPND_IMM_I;
            word.alu_code       = rcd_pkg::ALU_ADD;
          end
          default: word = '0;
        endcase
      end
      rcd_pkg::OPC_IMM: begin
        word.reg_write       = 1'b1;
        word.result_from_alu = 1'b1;
        word.operand_select  = rcd_pkg::OPND_IMM_I;
        unique case (f3) inside
          rcd_pkg::F3_ADD:                   word.alu_code = rcd_pkg::ALU_ADD;
          rcd_pkg::F3_SLT, rcd_pkg::F3_SLTU: word.alu_code = rcd_pkg::ALU_LT;
          rcd_pkg::F3_XOR:                   word.alu_code = rcd_pkg::ALU_XOR;
          rcd_pkg::F3_OR:                    word.alu_code = rcd_pkg::ALU_OR;
          rcd_pkg::F3_AND:                   word.alu_code = rcd_pkg::ALU_AND;
          // shift-immediates are not decoded
          default: word = '0;
        endcase
      end
      rcd_pkg::OPC_STORE: begin
        unique case (f3) inside
          rcd_pkg::F3_ADD, rcd_pkg::F3_SLL, rcd_pkg::F3_SLT: begin
            word.mem_write      = 1'b1;
            word.operand_select = rcd_pkg::OPND_IMM_S;
            word.alu_code       = rcd_pkg::ALU_ADD;
          end
          default: word = '0;
        endcase
      end
      rcd_pkg::OPC_BRANCH: begin
        unique case (f3) inside
          rcd_pkg::F3_SLT, rcd_pkg::F3_SLTU: word = '0;
          default: begin
            word.operand_select = rcd_pkg::OPND_IMM_B;
            word.alu_code       = rcd_pkg::ALU_ADD;
            word.conditional    = 1'b1;
          end
        endcase
      end
      rcd_pkg::OPC_LUI: begin
        word.reg_write       = 1'b1;
        word.operand_select  = rcd_pkg::OPND_IMM_U;
        word.alu_code        = rcd_pkg::ALU_PASSB;
        word.result_from_alu = 1'b1;
      end
      rcd_pkg::OPC_AUIPC: begin
        word.reg_write       = 1'b1;
        word.operand_select  = rcd_pkg::OPND_IMM_U;
        word.alu_code        = rcd_pkg::ALU_ADD;
        word.result_from_alu = 1'b1;
        word.pc_operand      = 1'b1;
      end
      rcd_pkg::OPC_JAL: begin
        word.reg_write       = 1'b1;
        word.operand_select  = rcd_pkg::OPND_IMM_J;
        word.alu_code        = rcd_pkg::ALU_INC;
        word.result_from_alu = 1'b1;
        word.conditional     = 1'b1;
        word.pc_operand      = 1'b1;
        word.jump            = 1'b1;
      end
      rcd_pkg::OPC_STOP: begin
        word.halt = 1'b1;
      end
      default: word = '0;
    endcase
  end

endmodule

// ----- rtl/core/rv32i_control_decoder.sv -----
// path: accepted request is held in the instruction register, decoded, then registered as the control word
// throughput: one request per cycle, limited only by output backpressure
// structure: instruction register, single-pass decode, control word register
// reset: synchronous active-high rst empties both stages; payload not cleared
module rv32i_control_decoder (
  input  logic              clk,
  input  logic              rst,
  rcd_insn_if.sink          instr,
  rcd_ctrl_if.source        ctrl
);

  `include "assert_macros.svh"

  logic                        s1_valid;
  logic [rcd_pkg::INSN_W-1:0]  s1_insn;
  logic                        out_valid;
  rcd_pkg::ctrl_word_t         out_word;
  rcd_pkg::ctrl_word_t         dec_word;
  logic                        s1_advance;

  // stage handshake, each stage moves when the next one is free
  assign s1_advance  = !out_valid || ctrl.ready;
  assign instr.ready = !s1_valid || s1_advance;

  rcd_decode u_decode (
    .insn (s1_insn),
    .word (dec_word)
  );

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (instr.ready) begin
        s1_valid <= instr.valid;
      end
      if (s1_advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (instr.valid && instr.ready) begin
      s1_insn <= instr.instruction;
    end
    if (s1_advance && s1_valid) begin
      out_word <= dec_word;
    end
  end

  // result channel
  assign ctrl.valid           = out_valid;
  assign ctrl.reg_write       = out_word.reg_write;
  assign ctrl.mem_write       = out_word.mem_write;
  assign ctrl.operand_select  = out_word.operand_select;
  assign ctrl.alu_code        = out_word.alu_code;
  assign ctrl.result_from_alu = out_word.result_from_alu;
  assign ctrl.conditional     = out_word.conditional;
  assign ctrl.halt            = out_word.halt;
  assign ctrl.pc_operand      = out_word.pc_operand;
  assign ctrl.jump            = out_word.jump;

  // checks
  `ASSERT_IMPLIES(a_out_from_s1, out_valid, $past(s1_valid) || $past(out_valid))
  `ASSERT_NEVER(a_no_write_both, out_valid && out_word.reg_write && out_word.mem_write)
  `ASSERT_IMPLIES(a_jump_flags, out_valid && ctrl.jump, ctrl.conditional && ctrl.pc_operand)
  `ASSERT_IMPLIES(a_halt_quiet, out_valid && ctrl.halt, !ctrl.reg_write && !ctrl.mem_write)

endmodule
